// ===== src/kmi_pkg.sv =====
`timescale 1ns / 1ps

package kmi_pkg;

  // Matrix geometry: eight columns per row, bit row*8+col
  localparam int MAT_W = 64;
  localparam int COL_N = 8;
  localparam int BIT_W = 6;
  localparam int CNT_W = 8;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_PULSE = 2'd0;
  localparam logic [1:0] REG_GAP   = 2'd1;
  localparam logic [1:0] REG_HOLD  = 2'd2;

  // Request operation codes
  localparam logic [2:0] FN_TICK       = 3'd0;
  localparam logic [2:0] FN_HOST_DOWN  = 3'd1;
  localparam logic [2:0] FN_HOST_UP    = 3'd2;
  localparam logic [2:0] FN_PULSE      = 3'd3;
  localparam logic [2:0] FN_SHIFT_SYNC = 3'd4;
  localparam logic [2:0] FN_CLEAR      = 3'd5;

  // Shift key location
  localparam logic [2:0] SHIFT_ROW = 3'd7;
  localparam logic [2:0] SHIFT_COL = 3'd0;
  localparam int         SHIFT_BIT = 56;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] key_row;
    logic [2:0] key_col;
    logic       flag;
  } in_req_t;

  typedef struct packed {
    logic [MAT_W-1:0] matrix;
    logic             pending;
    logic             accepted;
  } out_res_t;

  typedef struct packed {
    logic       shift;
    logic [2:0] col;
    logic [2:0] row;
  } ring_ent_t;

  // Control into the hold counter unit
  typedef struct packed {
    logic             load;
    logic             clr;
    logic             clr_all;
    logic             walk_start;
    logic [BIT_W-1:0] idx;
    logic [CNT_W-1:0] val;
  } hold_req_t;

  typedef struct packed {
    logic             rel_vld;
    logic [BIT_W-1:0] rel_idx;
    logic             walk_done;
    logic             others_act;
  } hold_sts_t;

  // Control into the pulse engine
  typedef struct packed {
    logic      enq;
    logic      tick;
    logic      clr_all;
    ring_ent_t ent;
  } pulse_req_t;

  typedef struct packed {
    logic             idle;
    logic             busy;
    logic             full;
    logic [MAT_W-1:0] press_mask;
    logic [MAT_W-1:0] rel_mask;
  } pulse_sts_t;

  function automatic logic [MAT_W-1:0] key_mask(input logic [2:0] row, input logic [2:0] col);
    key_mask = MAT_W'(1) << {row, col};
  endfunction

endpackage

// ===== src/key_matrix_injector_with_pulse_queue.sv =====
`timescale 1ns / 1ps

// Keyboard matrix injector with a typed-pulse queue.
// Requests enter on in_req and are taken at a clock edge with start high and
// busy low. Each request yields one result on out_res, marked by out_valid for
// a single cycle; the receiver has no way to stall it, so it must take it then.
// Host down, host up, pulse, shift sync and clear need no wait state:
// out_valid rises the cycle after the request and busy stays low, so one such
// request can be taken every cycle.
// A tick walks the hold counter memory one entry per cycle through its single
// read port, so busy stays high through the pulse step, the walk and the shift step;
// the result strobe comes in the cycle busy drops, when the next request may enter.
// Registers pulse_frames, gap_frames and hold_frames sit on the APB port at
// byte addresses 0, 4 and 8; write them only while the block is idle.
// Synchronous reset (rst_n low) empties the matrix, host state, counters and
// pulse queue, and loads the register defaults 3, 2 and 2. No clearing pass is
// needed: counter entries carry active bits cleared at once.
module key_matrix_injector_with_pulse_queue #(
  parameter int ROWS        = 8,
  parameter int QUEUE_SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  kmi_pkg::in_req_t             in_req,
  output logic                         out_valid,
  output kmi_pkg::out_res_t            out_res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kmi_pkg::CFG_AW-1:0]   paddr,
  input  logic [kmi_pkg::CFG_DW-1:0]   pwdata,
  output logic [kmi_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PT    = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [kmi_pkg::MAT_W-1:0] emu_r, emu_nxt;
  logic [kmi_pkg::MAT_W-1:0] host_r, host_nxt;
  logic                      pend_r, pend_nxt;
  logic                      out_vld_r, out_vld_nxt;
  logic                      acc_r, acc_nxt;
  logic [7:0]                pf_r, gf_r, hf_r;

  kmi_pkg::hold_req_t  hreq;
  kmi_pkg::hold_sts_t  hsts;
  kmi_pkg::pulse_req_t preq;
  kmi_pkg::pulse_sts_t psts;

  logic                      accept;
  logic                      row_ok, shift_ok;
  logic                      others;
  logic                      cfg_we;
  logic [kmi_pkg::MAT_W-1:0] key_m, shift_m;
  logic [kmi_pkg::BIT_W-1:0] key_idx;

  assign accept   = start && !busy;
  assign row_ok   = ({1'b0, in_req.key_row} < 4'(ROWS));
  assign shift_ok = ({1'b0, kmi_pkg::SHIFT_ROW} < 4'(ROWS));
  assign key_m    = kmi_pkg::key_mask(in_req.key_row, in_req.key_col);
  assign shift_m  = kmi_pkg::key_mask(kmi_pkg::SHIFT_ROW, kmi_pkg::SHIFT_COL);
  assign key_idx  = {in_req.key_row, in_req.key_col};
  assign others   = (|(host_r & ~shift_m)) || hsts.others_act || psts.busy;

  kmi_hold #(
    .ROWS (ROWS)
  ) u_hold (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .sts   (hsts)
  );

  kmi_pulse #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_pulse (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (preq),
    .pulse_frames (pf_r),
    .gap_frames   (gf_r),
    .sts          (psts)
  );

  // Pulse engine requests
  always_comb begin
    preq.enq     = (state_r == S_IDLE) && accept && (in_req.func == kmi_pkg::FN_PULSE)
                 && row_ok;
    preq.tick    = (state_r == S_PT);
    preq.clr_all = (state_r == S_IDLE) && accept && (in_req.func == kmi_pkg::FN_CLEAR);
    preq.ent.shift = in_req.flag;
    preq.ent.col   = in_req.key_col;
    preq.ent.row   = in_req.key_row;
  end

  // Request sequencer
  always_comb begin
    state_nxt   = state_r;
    emu_nxt     = emu_r;
    host_nxt    = host_r;
    pend_nxt    = pend_r;
    out_vld_nxt = 1'b0;
    acc_nxt     = acc_r;
    hreq        = '0;
    hreq.idx    = key_idx;
    hreq.val    = hf_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_vld_nxt = 1'b1;
          acc_nxt     = 1'b1;
          case (in_req.func)
            kmi_pkg::FN_TICK: begin
              out_vld_nxt = 1'b0;
              state_nxt   = S_PT;
            end
            kmi_pkg::FN_HOST_DOWN: begin
              if (row_ok) begin
                host_nxt = host_r | key_m;
                emu_nxt  = emu_r | key_m;
                hreq.clr = 1'b1;
              end
            end
            kmi_pkg::FN_HOST_UP: begin
              if (row_ok) begin
                host_nxt  = host_r & ~key_m;
                hreq.load = 1'b1;
                if (hf_r == '0) emu_nxt = emu_r & ~key_m;
              end
            end
            kmi_pkg::FN_PULSE: begin
              if (row_ok) begin
                emu_nxt = emu_r | psts.press_mask;
                acc_nxt = psts.idle || !psts.full;
              end
            end
            kmi_pkg::FN_SHIFT_SYNC: begin
              hreq.idx = kmi_pkg::BIT_W'(kmi_pkg::SHIFT_BIT);
              if (in_req.flag) begin
                pend_nxt = 1'b0;
                if (shift_ok) begin
                  host_nxt = host_r | shift_m;
                  emu_nxt  = emu_r | shift_m;
                  hreq.clr = 1'b1;
                end
              end else if (others) begin
                pend_nxt = 1'b1;
              end else if (shift_ok) begin
                host_nxt  = host_r & ~shift_m;
                hreq.load = 1'b1;
                if (hf_r == '0) emu_nxt = emu_r & ~shift_m;
              end
            end
            kmi_pkg::FN_CLEAR: begin
              emu_nxt      = '0;
              host_nxt     = '0;
              pend_nxt     = 1'b0;
              hreq.clr_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      // Pulse step, then host-held keys pressed, then counter walk
      S_PT: begin
        emu_nxt         = ((emu_r & ~psts.rel_mask) | psts.press_mask) | host_r;
        hreq.walk_start = 1'b1;
        state_nxt       = S_WALK;
      end
      S_WALK: begin
        if (hsts.rel_vld) emu_nxt = emu_r & ~(kmi_pkg::MAT_W'(1) << hsts.rel_idx);
        if (hsts.walk_done) state_nxt = S_SHIFT;
      end
      // Deferred shift release once nothing else is active
      S_SHIFT: begin
        hreq.idx = kmi_pkg::BIT_W'(kmi_pkg::SHIFT_BIT);
        if (pend_r && !others) begin
          pend_nxt = 1'b0;
          host_nxt = host_r & ~shift_m;
          hreq.clr = shift_ok;
          emu_nxt  = emu_r & ~shift_m;
        end
        out_vld_nxt = 1'b1;
        acc_nxt     = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      emu_r     <= '0;
      host_r    <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
      acc_r     <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      emu_r     <= emu_nxt;
      host_r    <= host_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
      acc_r     <= acc_nxt;
    end
  end

  // Configuration registers
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pf_r <= 8'd3;
      gf_r <= 8'd2;
      hf_r <= 8'd2;
    end else if (cfg_we) begin
      case (paddr[3:2])
        kmi_pkg::REG_PULSE: pf_r <= pwdata[7:0];
        kmi_pkg::REG_GAP:   gf_r <= pwdata[7:0];
        kmi_pkg::REG_HOLD:  hf_r <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      kmi_pkg::REG_PULSE: prdata = {24'd0, pf_r};
      kmi_pkg::REG_GAP:   prdata = {24'd0, gf_r};
      kmi_pkg::REG_HOLD:  prdata = {24'd0, hf_r};
      default:            prdata = '0;
    endcase
  end

  // Result ports show the state left by the request
  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_vld_r;
  assign out_res.matrix   = emu_r;
  assign out_res.pending  = !psts.idle;
  assign out_res.accepted = acc_r;

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  a_short_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.func != kmi_pkg::FN_TICK)) |=> out_vld_r)
    else $error("one-cycle request gave no result");

  a_tick_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.func == kmi_pkg::FN_TICK)) |=> ((state_r == S_PT) && !out_vld_r))
    else $error("tick did not enter pulse step");

  a_shift_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |=> (out_vld_r && (state_r == S_IDLE)))
    else $error("tick ended without result");

  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    hsts.walk_done |-> (state_r == S_WALK))
    else $error("counter walk finished outside walk state");

endmodule

// ===== src/kmi_hold.sv =====
`timescale 1ns / 1ps

module kmi_hold #(
  parameter int ROWS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kmi_pkg::hold_req_t  req,
  output kmi_pkg::hold_sts_t  sts
);

  localparam int DEPTH = ROWS * kmi_pkg::COL_N;
  localparam int AW    = $clog2(DEPTH);

  // Hold counters; an entry without its active bit reads as zero
  logic [kmi_pkg::CNT_W-1:0] mem [DEPTH];
  logic [kmi_pkg::CNT_W-1:0] rd_r;
  logic [DEPTH-1:0]          act_r, act_nxt;

  logic          walking_r, walking_nxt;
  logic [AW-1:0] wcnt_r, wcnt_nxt;
  logic          p1_vld_r;
  logic [AW-1:0] p1_idx_r;

  logic                      req_ok;
  logic [AW-1:0]             req_a;
  logic                      we;
  logic [AW-1:0]             wa;
  logic [kmi_pkg::CNT_W-1:0] wd;
  logic [kmi_pkg::CNT_W-1:0] dec;
  logic                      hit;
  logic                      rel;
  logic                      others;

  assign req_ok = ({1'b0, req.idx} < (kmi_pkg::BIT_W + 1)'(DEPTH));
  assign req_a  = req.idx[AW-1:0];

  // Second walk stage: decrement the entry read last cycle
  assign hit = p1_vld_r && act_r[p1_idx_r];
  assign dec = rd_r - 1'b1;
  assign rel = hit && (dec == '0);

  // Single write port: walk write-back or host release load
  always_comb begin
    we = 1'b0;
    wa = req_a;
    wd = req.val;
    if (hit) begin
      we = 1'b1;
      wa = p1_idx_r;
      wd = dec;
    end else if (req.load && req_ok) begin
      we = 1'b1;
    end
  end

  // Active bits
  always_comb begin
    act_nxt = act_r;
    if (req.clr_all) begin
      act_nxt = '0;
    end else begin
      if (req.load && req_ok) act_nxt[req_a] = (req.val != '0);
      if (req.clr && req_ok)  act_nxt[req_a] = 1'b0;
      if (rel)                act_nxt[p1_idx_r] = 1'b0;
    end
  end

  // Walk address counter
  always_comb begin
    walking_nxt = walking_r;
    wcnt_nxt    = wcnt_r;
    if (req.walk_start) begin
      walking_nxt = 1'b1;
      wcnt_nxt    = '0;
    end else if (walking_r) begin
      if (wcnt_r == AW'(DEPTH - 1)) begin
        walking_nxt = 1'b0;
      end else begin
        wcnt_nxt = wcnt_r + 1'b1;
      end
    end
  end

  // Any counter running apart from shift's
  always_comb begin
    others = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i != kmi_pkg::SHIFT_BIT) others = others | act_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= '0;
      walking_r <= 1'b0;
      wcnt_r    <= '0;
      p1_vld_r  <= 1'b0;
    end else begin
      act_r     <= act_nxt;
      walking_r <= walking_nxt;
      wcnt_r    <= wcnt_nxt;
      p1_vld_r  <= walking_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r <= wcnt_r;
  end

  // Counter memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[wcnt_r];
  end

  assign sts.rel_vld    = rel;
  assign sts.rel_idx    = kmi_pkg::BIT_W'(p1_idx_r);
  assign sts.walk_done  = p1_vld_r && (p1_idx_r == AW'(DEPTH - 1));
  assign sts.others_act = others;

endmodule

// ===== src/kmi_pulse.sv =====
`timescale 1ns / 1ps

module kmi_pulse #(
  parameter int QUEUE_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kmi_pkg::pulse_req_t  req,
  input  logic [7:0]           pulse_frames,
  input  logic [7:0]           gap_frames,
  output kmi_pkg::pulse_sts_t  sts
);

  localparam int QW = $clog2(QUEUE_SLOTS);

  // Pulse ring, read at the head every cycle
  kmi_pkg::ring_ent_t ring [QUEUE_SLOTS];
  kmi_pkg::ring_ent_t ring_rd_r;

  logic [QW-1:0] head_r, head_nxt;
  logic [QW-1:0] tail_r, tail_nxt;
  logic [7:0]    gap_r, gap_nxt;
  logic          busy_r, busy_nxt;
  kmi_pkg::ring_ent_t cur_r, cur_nxt;
  logic [7:0]    frames_r, frames_nxt;

  logic [QW-1:0] head_inc, tail_inc;
  logic          empty, full, idle;
  logic          we;
  logic          st_vld;
  kmi_pkg::ring_ent_t st_ent;
  logic [7:0]    fdec;
  logic [kmi_pkg::MAT_W-1:0] press_m, rel_m;

  assign head_inc = (head_r == QW'(QUEUE_SLOTS - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == QW'(QUEUE_SLOTS - 1)) ? '0 : tail_r + 1'b1;
  assign empty    = (head_r == tail_r);
  assign full     = (tail_inc == head_r);
  assign idle     = !busy_r && (gap_r == '0) && empty;
  assign fdec     = (frames_r == '0) ? '0 : frames_r - 1'b1;

  // Clear, enqueue, start and tick step
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    gap_nxt    = gap_r;
    busy_nxt   = busy_r;
    cur_nxt    = cur_r;
    frames_nxt = frames_r;
    we         = 1'b0;
    st_vld     = 1'b0;
    st_ent     = req.ent;
    rel_m      = '0;
    if (req.clr_all) begin
      busy_nxt = 1'b0;
      gap_nxt  = '0;
      head_nxt = '0;
      tail_nxt = '0;
    end else if (req.enq) begin
      if (idle) begin
        st_vld = 1'b1;
      end else if (!full) begin
        we       = 1'b1;
        tail_nxt = tail_inc;
      end
    end else if (req.tick) begin
      if (gap_r != '0) begin
        gap_nxt = gap_r - 1'b1;
        // gap ran out: next queued pulse starts
        if ((gap_r == 8'd1) && !empty) begin
          st_vld   = 1'b1;
          st_ent   = ring_rd_r;
          head_nxt = head_inc;
        end
      end else if (busy_r) begin
        if (fdec == '0) begin
          rel_m = kmi_pkg::key_mask(cur_r.row, cur_r.col)
                | (cur_r.shift ? kmi_pkg::key_mask(kmi_pkg::SHIFT_ROW, kmi_pkg::SHIFT_COL)
                               : '0);
          busy_nxt = 1'b0;
          if (!empty) gap_nxt = (gap_frames == '0) ? 8'd1 : gap_frames;
        end else begin
          frames_nxt = fdec;
        end
      end
    end
    press_m = '0;
    if (st_vld) begin
      cur_nxt    = st_ent;
      frames_nxt = pulse_frames;
      busy_nxt   = 1'b1;
      press_m    = kmi_pkg::key_mask(st_ent.row, st_ent.col)
                 | (st_ent.shift ? kmi_pkg::key_mask(kmi_pkg::SHIFT_ROW, kmi_pkg::SHIFT_COL)
                                 : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      gap_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      gap_r  <= gap_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    frames_r <= frames_nxt;
  end

  // Ring memory
  always_ff @(posedge clk) begin
    if (we) ring[tail_r] <= req.ent;
    ring_rd_r <= ring[head_r];
  end

  assign sts.idle       = idle;
  assign sts.busy       = busy_r;
  assign sts.full       = full;
  assign sts.press_mask = press_m;
  assign sts.rel_mask   = rel_m;

endmodule

// ===== tb/key_matrix_injector_with_pulse_queue_test.sv =====
`timescale 1ns / 1ps

module key_matrix_injector_with_pulse_queue_test;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         RING_SLOTS  = 16;
  localparam logic [2:0] FN_SPARE6   = 3'd6;
  localparam logic [2:0] FN_SPARE7   = 3'd7;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  // One row of the directed plan; res is used only where typed is set
  typedef struct packed {
    kmi_pkg::in_req_t  req;
    logic              typed;
    kmi_pkg::out_res_t res;
  } step_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  kmi_pkg::in_req_t             in_req;
  logic                         out_valid;
  kmi_pkg::out_res_t            out_res;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [kmi_pkg::CFG_AW-1:0]   paddr;
  logic [kmi_pkg::CFG_DW-1:0]   pwdata;
  logic [kmi_pkg::CFG_DW-1:0]   prdata;
  logic                         pready;

  kmi_pkg::out_res_t            result_q[$];
  int                           fails;
  int                           cycles;
  int                           idle_pct;

  // Shadow of the injector state
  logic [kmi_pkg::MAT_W-1:0]    mat_q;
  logic [kmi_pkg::MAT_W-1:0]    host_q;
  logic [7:0]                   hold_cnt[64];
  logic                         shift_defer;
  logic                         pulse_on;
  kmi_pkg::ring_ent_t           pulse_key;
  logic [7:0]                   pulse_left;
  logic [7:0]                   gap_left;
  kmi_pkg::ring_ent_t           ring_mem[RING_SLOTS];
  logic [3:0]                   ring_rd;
  logic [3:0]                   ring_wr;
  logic [7:0]                   pulse_len;
  logic [7:0]                   gap_len;
  logic [7:0]                   hold_len;

  always #5 clk = ~clk;

  key_matrix_injector_with_pulse_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // ---------------------------------------------------------------------
  // Matrix predictor
  // ---------------------------------------------------------------------
  function automatic void clear_state();
    mat_q       = '0;
    host_q      = '0;
    shift_defer = 1'b0;
    pulse_on    = 1'b0;
    gap_left    = '0;
    ring_rd     = '0;
    ring_wr     = '0;
    for (int b = 0; b < 64; b++) hold_cnt[b] = '0;
  endfunction

  function automatic logic queue_idle();
    return !pulse_on && gap_left == 0 && ring_rd == ring_wr;
  endfunction

  // Any non-shift key held, counting down, or a pulse in flight
  function automatic logic others_pressed();
    for (int b = 0; b < 64; b++) begin
      if (b != kmi_pkg::SHIFT_BIT && (host_q[b] || hold_cnt[b] != 0)) return 1'b1;
    end
    return pulse_on;
  endfunction

  function automatic void launch(kmi_pkg::ring_ent_t e);
    pulse_key  = e;
    pulse_left = pulse_len;
    pulse_on   = 1'b1;
    mat_q[{e.row, e.col}] = 1'b1;
    if (e.shift) mat_q[kmi_pkg::SHIFT_BIT] = 1'b1;
  endfunction

  function automatic void host_key(logic [5:0] idx, logic down);
    if (down) begin
      host_q[idx]   = 1'b1;
      hold_cnt[idx] = '0;
      mat_q[idx]    = 1'b1;
    end else begin
      host_q[idx]   = 1'b0;
      hold_cnt[idx] = hold_len;
      if (hold_len == 0) mat_q[idx] = 1'b0;
    end
  endfunction

  function automatic void frame_tick();
    // pulse engine: gap first, else the active pulse
    if (gap_left != 0) begin
      gap_left--;
      if (gap_left == 0 && ring_rd != ring_wr) begin
        launch(ring_mem[ring_rd]);
        ring_rd++;
      end
    end else if (pulse_on) begin
      if (pulse_left != 0) pulse_left--;
      if (pulse_left == 0) begin
        mat_q[{pulse_key.row, pulse_key.col}] = 1'b0;
        if (pulse_key.shift) mat_q[kmi_pkg::SHIFT_BIT] = 1'b0;
        pulse_on = 1'b0;
        if (ring_rd != ring_wr) gap_left = (gap_len == 0) ? 8'd1 : gap_len;
      end
    end
    // host keys and hold counters
    for (int b = 0; b < 64; b++) begin
      if (host_q[b]) begin
        mat_q[b] = 1'b1;
      end else if (hold_cnt[b] != 0) begin
        hold_cnt[b]--;
        if (hold_cnt[b] == 0) mat_q[b] = 1'b0;
      end
    end
    // deferred shift release
    if (shift_defer && !others_pressed()) begin
      shift_defer                  = 1'b0;
      host_q[kmi_pkg::SHIFT_BIT]   = 1'b0;
      hold_cnt[kmi_pkg::SHIFT_BIT] = '0;
      mat_q[kmi_pkg::SHIFT_BIT]    = 1'b0;
    end
  endfunction

  function automatic kmi_pkg::out_res_t predict_matrix(kmi_pkg::in_req_t q);
    kmi_pkg::out_res_t  res;
    kmi_pkg::ring_ent_t e;
    logic [3:0]         nxt;
    logic               ok;
    ok = 1'b1;
    case (q.func)
      kmi_pkg::FN_TICK:      frame_tick();
      kmi_pkg::FN_HOST_DOWN: host_key({q.key_row, q.key_col}, 1'b1);
      kmi_pkg::FN_HOST_UP:   host_key({q.key_row, q.key_col}, 1'b0);
      kmi_pkg::FN_PULSE: begin
        e.shift = q.flag;
        e.col   = q.key_col;
        e.row   = q.key_row;
        if (queue_idle()) begin
          launch(e);
        end else begin
          nxt = ring_wr + 4'd1;
          if (nxt == ring_rd) begin
            ok = 1'b0;
          end else begin
            ring_mem[ring_wr] = e;
            ring_wr = nxt;
          end
        end
      end
      kmi_pkg::FN_SHIFT_SYNC: begin
        if (q.flag) begin
          shift_defer = 1'b0;
          host_key({kmi_pkg::SHIFT_ROW, kmi_pkg::SHIFT_COL}, 1'b1);
        end else if (others_pressed()) begin
          shift_defer = 1'b1;
        end else begin
          host_key({kmi_pkg::SHIFT_ROW, kmi_pkg::SHIFT_COL}, 1'b0);
        end
      end
      kmi_pkg::FN_CLEAR: clear_state();
      default: ;
    endcase
    res.matrix   = mat_q;
    res.pending  = !queue_idle();
    res.accepted = ok;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver and configuration access
  // ---------------------------------------------------------------------
  function automatic kmi_pkg::in_req_t rand_req();
    kmi_pkg::in_req_t q;
    int               pick;
    q.key_row = 3'($urandom_range(7));
    q.key_col = 3'($urandom_range(7));
    q.flag    = 1'($urandom_range(1));
    pick      = $urandom_range(99);
    if (pick < 30)      q.func = kmi_pkg::FN_TICK;
    else if (pick < 52) q.func = kmi_pkg::FN_PULSE;
    else if (pick < 68) q.func = kmi_pkg::FN_HOST_DOWN;
    else if (pick < 84) q.func = kmi_pkg::FN_HOST_UP;
    else if (pick < 93) q.func = kmi_pkg::FN_SHIFT_SYNC;
    else if (pick < 96) q.func = kmi_pkg::FN_CLEAR;
    else if (pick < 98) q.func = FN_SPARE6;
    else                q.func = FN_SPARE7;
    // host ops on the shift key itself now and then
    if ((q.func == kmi_pkg::FN_HOST_DOWN || q.func == kmi_pkg::FN_HOST_UP)
        && $urandom_range(9) == 0) begin
      q.key_row = kmi_pkg::SHIFT_ROW;
      q.key_col = kmi_pkg::SHIFT_COL;
    end
    return q;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(input kmi_pkg::in_req_t q, input logic typed,
                       input kmi_pkg::out_res_t want);
    kmi_pkg::out_res_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start  = 1'b0;
      in_req = kmi_pkg::in_req_t'($urandom);
      @(negedge clk);
    end
    start  = 1'b1;
    in_req = q;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = predict_matrix(q);
    result_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    kmi_pkg::in_req_t q;
    int               sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(14) == 0) begin
        // typing burst, at its longest enough to overrun the ring
        repeat ($urandom_range(6, 18)) begin
          q       = rand_req();
          q.func  = kmi_pkg::FN_PULSE;
          issue(q, 1'b0, '0);
          sent++;
        end
      end else begin
        issue(rand_req(), 1'b0, '0);
        sent++;
      end
    end
    start = 1'b0;
  endtask

  task automatic drain();
    while (result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'($urandom), v};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      kmi_pkg::REG_PULSE: pulse_len = v;
      kmi_pkg::REG_GAP:   gap_len   = v;
      kmi_pkg::REG_HOLD:  hold_len  = v;
      default: ;
    endcase
  endtask

  task automatic cfg_check(input logic [1:0] idx, input logic [7:0] v);
    logic [7:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    got = prdata[7:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== v) begin
      $error("prdata[%0d]: expected %0d, got %0d", idx, v, got);
      fails++;
    end
  endtask

  task automatic set_regs(input logic [7:0] p, input logic [7:0] g, input logic [7:0] h);
    drain();
    cfg_write(kmi_pkg::REG_PULSE, p);
    cfg_write(kmi_pkg::REG_GAP, g);
    cfg_write(kmi_pkg::REG_HOLD, h);
    cfg_check(kmi_pkg::REG_PULSE, p);
    cfg_check(kmi_pkg::REG_GAP, g);
    cfg_check(kmi_pkg::REG_HOLD, h);
  endtask

  function automatic step_t mk(logic [2:0] fn, logic [2:0] r, logic [2:0] c, logic f,
                               logic typed, logic [63:0] m, logic p, logic a);
    step_t s;
    s.req.func     = fn;
    s.req.key_row  = r;
    s.req.key_col  = c;
    s.req.flag     = f;
    s.typed        = typed;
    s.res.matrix   = m;
    s.res.pending  = p;
    s.res.accepted = a;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    kmi_pkg::out_res_t want;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        $error("result strobe with no request outstanding");
        fails++;
      end else begin
        want = result_q.pop_front();
        if (out_res.matrix !== want.matrix) begin
          $error("matrix: expected %h, got %h", want.matrix, out_res.matrix);
          fails++;
        end
        if (out_res.pending !== want.pending) begin
          $error("pending: expected %b, got %b", want.pending, out_res.pending);
          fails++;
        end
        if (out_res.accepted !== want.accepted) begin
          $error("accepted: expected %b, got %b", want.accepted, out_res.accepted);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    step_t steps[$];
    fails    = 0;
    cycles   = 0;
    idle_pct = 28;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_req   = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    pulse_len = 8'd3;
    gap_len   = 8'd2;
    hold_len  = 8'd2;
    pulse_key = '0;
    pulse_left = '0;
    for (int i = 0; i < RING_SLOTS; i++) ring_mem[i] = '0;
    clear_state();

    // directed plan, register defaults
    steps.push_back(mk(kmi_pkg::FN_HOST_DOWN,  3'd0, 3'd0, 1'b0, 1'b1, 64'h1, 1'b0, 1'b1));
    steps.push_back(mk(kmi_pkg::FN_HOST_DOWN,  3'd7, 3'd7, 1'b1, 1'b1,
                       64'h8000_0000_0000_0001, 1'b0, 1'b1));
    steps.push_back(mk(kmi_pkg::FN_HOST_UP,    3'd7, 3'd7, 1'b0, 1'b1,
                       64'h8000_0000_0000_0001, 1'b0, 1'b1));
    steps.push_back(mk(kmi_pkg::FN_TICK,       3'd0, 3'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_TICK,       3'd5, 3'd2, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_HOST_UP,    3'd0, 3'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_SHIFT_SYNC, 3'd0, 3'd0, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_HOST_DOWN,  3'd3, 3'd5, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    // shift up while another key is down: deferred
    steps.push_back(mk(kmi_pkg::FN_SHIFT_SYNC, 3'd0, 3'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_TICK,       3'd0, 3'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_HOST_UP,    3'd3, 3'd5, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_TICK,       3'd0, 3'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_TICK,       3'd0, 3'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_TICK,       3'd0, 3'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    // pulse with shift, then two queued behind it
    steps.push_back(mk(kmi_pkg::FN_PULSE,      3'd2, 3'd4, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_PULSE,      3'd5, 3'd1, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_PULSE,      3'd7, 3'd7, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    repeat (4) steps.push_back(mk(kmi_pkg::FN_TICK, 3'd0, 3'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(FN_SPARE6,              3'd7, 3'd7, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(FN_SPARE7,              3'd0, 3'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    steps.push_back(mk(kmi_pkg::FN_CLEAR,      3'd0, 3'd0, 1'b0, 1'b1, 64'h0, 1'b0, 1'b1));
    steps.push_back(mk(kmi_pkg::FN_PULSE,      3'd0, 3'd0, 1'b1, 1'b1,
                       64'h0100_0000_0000_0001, 1'b1, 1'b1));
    steps.push_back(mk(kmi_pkg::FN_CLEAR,      3'd6, 3'd3, 1'b1, 1'b1, 64'h0, 1'b0, 1'b1));

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (steps[i]) issue(steps[i].req, steps[i].typed, steps[i].res);
    start = 1'b0;
    random_phase(75);

    // zero lengths: pulse released next tick, gap acts as one, hold clears at once
    set_regs(8'd0, 8'd0, 8'd0);
    cfg_write(REG_SPARE, 8'($urandom));
    random_phase(75);

    // longest lengths: ring fills and drops pulses
    set_regs(8'd255, 8'd255, 8'd255);
    random_phase(60);

    // shortest nonzero lengths, back-to-back requests
    idle_pct = 0;
    set_regs(8'd1, 8'd1, 8'd1);
    random_phase(80);
    idle_pct = 28;

    set_regs(8'($urandom_range(2, 6)), 8'($urandom_range(1, 4)), 8'($urandom_range(1, 6)));
    random_phase(80);

    set_regs(8'($urandom_range(0, 12)), 8'($urandom_range(1, 12)),
             8'($urandom_range(0, 12)));
    random_phase(80);

    // let the last tick finish
    while (result_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/kmi_pkg.sv
src/kmi_hold.sv
src/kmi_pulse.sv
src/key_matrix_injector_with_pulse_queue.sv
tb/key_matrix_injector_with_pulse_queue_test.sv
